### rtl/core/wfs_pkg.sv
// Shared types and constants of the windowed flow statistics block.
// Used by every module under rtl/core but wfs_ram; depends on nothing.
package wfs_pkg;

  localparam int FlowSlotsDef = 64;

  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;

  localparam int DivNumW = 112;
  localparam int DivDenW = 64;
  localparam int DivQuoW = 48;
  localparam int RootInW = 48;
  localparam int RootW   = 24;

  localparam logic [23:0] Max24 = 24'hFF_FFFF;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam logic [63:0] Max64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] Max16 = 16'hFFFF;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_FIRST_START   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_TCP  = 2'd1,
    CLS_UDP  = 2'd2,
    CLS_ICMP = 2'd3
  } cls_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] key;
    logic [15:0] len;
    logic [31:0] sq;
    cls_t        cls;
    logic [47:0] now;
  } item_t;

  typedef struct packed {
    logic [31:0] pkts;
    logic [47:0] bytes;
    logic [63:0] sqsum;
    logic [47:0] start;
    cls_t        cls;
  } stat_t;

  typedef struct packed {
    logic [31:0] pkt_total;
    logic [47:0] byte_total;
    logic [23:0] mean_size;
    logic [23:0] std_size;
    logic [47:0] flow_age_ms;
    logic        tcp_flag;
    logic        udp_flag;
    logic        icmp_flag;
    logic [15:0] dropped_packets;
    logic        last_record;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CMP,
    ST_UPD,
    ST_NEW,
    ST_TICK,
    ST_FL_RD,
    ST_FL_MUL,
    ST_FL_MEAN,
    ST_FL_STD,
    ST_FL_ROOT,
    ST_EMIT,
    ST_CLOSE
  } state_t;

  function automatic cls_t classify(input logic [7:0] proto);
    cls_t c;
    c = CLS_NONE;
    if (proto == ProtoTcp) c = CLS_TCP;
    else if (proto == ProtoUdp) c = CLS_UDP;
    else if (proto == ProtoIcmp) c = CLS_ICMP;
    return c;
  endfunction

endpackage

### rtl/core/wfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/core/wfs_front.sv
// Front end: accepts items, classifies protocol, squares the length, and
// holds them in a two-entry queue for the back end. Depends on wfs_pkg.
module wfs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          operation,
  input  logic [63:0]   flow_key,
  input  logic [15:0]   packet_bytes,
  input  logic [7:0]    protocol_number,
  input  logic [47:0]   now_ms,
  output logic          item_valid,
  input  logic          item_ready,
  output wfs_pkg::item_t item
);
  import wfs_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      fresh;

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    fresh.op  = op_t'(operation);
    fresh.key = flow_key;
    fresh.len = packet_bytes;
    fresh.sq  = packet_bytes * packet_bytes;
    fresh.cls = classify(protocol_number);
    fresh.now = now_ms;
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= fresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/wfs_div.sv
// Restoring divider, one quotient bit per cycle; keeps the low quotient
// bits and flags any higher one. Depends on wfs_pkg.
module wfs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [wfs_pkg::DivNumW-1:0] dividend,
  input  logic [wfs_pkg::DivDenW-1:0] divisor,
  output logic               done,
  output logic [wfs_pkg::DivQuoW-1:0] quotient,
  output logic               overflow
);
  import wfs_pkg::*;

  localparam int CntW = $clog2(DivNumW);

  logic [DivNumW-1:0] dvd;
  logic [DivDenW-1:0] den;
  logic [DivDenW-1:0] rem;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic [DivDenW:0]   r_sh;
  logic               ge;

  assign r_sh = {rem, dvd[DivNumW-1]};
  assign ge   = (r_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
      overflow <= 1'b0;
      cnt      <= '0;
    end else if (busy) begin
      dvd      <= dvd << 1;
      rem      <= ge ? DivDenW'(r_sh - {1'b0, den}) : DivDenW'(r_sh);
      quotient <= {quotient[DivQuoW-2:0], ge};
      overflow <= overflow | quotient[DivQuoW-1];
      cnt      <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CntW'(DivNumW - 1));
      if (start) busy <= 1'b1;
      else if (busy && (cnt == CntW'(DivNumW - 1))) busy <= 1'b0;
    end
  end

endmodule

### rtl/core/wfs_sqrt.sv
// Integer square root, one result bit per cycle (bit-pair recurrence).
// Depends on wfs_pkg.
module wfs_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [wfs_pkg::RootInW-1:0] radicand,
  output logic               done,
  output logic [wfs_pkg::RootW-1:0]   root
);
  import wfs_pkg::*;

  localparam int W    = RootInW + 2;
  localparam int CntW = $clog2(RootW);

  logic [W-1:0]    x;
  logic [W-1:0]    res;
  logic [W-1:0]    bitv;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [W-1:0]    trial;
  logic            ge;

  assign trial = res + bitv;
  assign ge    = (x >= trial);
  assign root  = res[RootW-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= W'(radicand);
      res  <= '0;
      bitv <= W'(1) << (RootInW - 2);
      cnt  <= '0;
    end else if (busy) begin
      if (ge) begin
        x   <= x - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CntW'(RootW - 1));
      if (start) busy <= 1'b1;
      else if (busy && (cnt == CntW'(RootW - 1))) busy <= 1'b0;
    end
  end

endmodule

### rtl/core/wfs_back.sv
// Back end: flow table lookup and update, window close and record flush.
// Depends on wfs_pkg, wfs_ram, wfs_div and wfs_sqrt.
module wfs_back #(
  parameter int FLOW_SLOTS = wfs_pkg::FlowSlotsDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_en,
  input  logic           cfg_index,
  input  logic [47:0]    cfg_data,
  input  logic           item_valid,
  output logic           item_ready,
  input  wfs_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output wfs_pkg::rec_t  rec
);
  import wfs_pkg::*;

  localparam int SlotW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CntW  = $clog2(FLOW_SLOTS + 1);

  state_t state, state_next;

  logic [31:0]     window_length;
  logic [47:0]     window_start;
  logic [48:0]     win_end;
  logic [CntW-1:0] slots_used;
  logic [15:0]     drop;
  item_t           cur;
  logic [SlotW-1:0] idx;
  logic [95:0]     acc_a;
  logic [95:0]     acc_b;
  logic [63:0]     den;
  logic [63:0]     prod;
  logic [2:0]      mstep;
  logic [23:0]     mean;
  logic [23:0]     stdv;

  logic            key_we;
  logic            stat_we;
  logic [SlotW-1:0] waddr;
  stat_t           stat_wdata;
  logic            rd_en;
  logic [63:0]     key_q;
  stat_t           stat_q;

  logic            div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic            div_done;
  logic [DivQuoW-1:0] div_q;
  logic            div_ovf;
  logic            sq_start;
  logic            sq_done;
  logic [RootW-1:0] sq_root;

  logic            is_last;
  logic            out_free;
  logic            std_needed;
  logic [48:0]     tick_end;
  logic [48:0]     bytes_sum;
  logic [64:0]     sq_sum;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [63:0]     mul_p;
  logic [95:0]     diff;

  wfs_ram #(.WIDTH(64), .DEPTH(FLOW_SLOTS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(cur.key),
    .re(rd_en), .raddr(idx), .rdata(key_q)
  );

  wfs_ram #(.WIDTH($bits(stat_t)), .DEPTH(FLOW_SLOTS)) u_stat_ram (
    .clk(clk), .we(stat_we), .waddr(waddr), .wdata(stat_wdata),
    .re(rd_en), .raddr(idx), .rdata(stat_q)
  );

  wfs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_q), .overflow(div_ovf)
  );

  wfs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(div_q),
    .done(sq_done), .root(sq_root)
  );

  assign is_last    = ((CntW'(idx) + CntW'(1)) == slots_used);
  assign out_free   = !out_valid || out_ready;
  assign std_needed = (stat_q.pkts >= 32'd2) && (acc_a >= acc_b);
  assign tick_end   = {1'b0, window_start} + 49'(window_length);
  assign bytes_sum  = {1'b0, stat_q.bytes} + 49'(cur.len);
  assign sq_sum     = {1'b0, stat_q.sqsum} + 65'(cur.sq);
  assign diff       = acc_a - acc_b;
  assign mul_p      = mul_a * mul_b;

  always_comb begin
    unique case (mstep)
      3'd0:    begin mul_a = stat_q.pkts;         mul_b = stat_q.sqsum[31:0];  end
      3'd1:    begin mul_a = stat_q.pkts;         mul_b = stat_q.sqsum[63:32]; end
      3'd2:    begin mul_a = stat_q.bytes[31:0];  mul_b = stat_q.bytes[31:0];  end
      3'd3:    begin mul_a = stat_q.bytes[31:0];  mul_b = 32'(stat_q.bytes[47:32]); end
      3'd4:    begin mul_a = 32'(stat_q.bytes[47:32]); mul_b = 32'(stat_q.bytes[47:32]); end
      default: begin mul_a = stat_q.pkts;         mul_b = stat_q.pkts - 32'd1; end
    endcase
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    key_we     = 1'b0;
    stat_we    = 1'b0;
    waddr      = idx;
    stat_wdata = stat_q;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    div_num    = DivNumW'({stat_q.bytes, 8'd0});
    div_den    = DivDenW'(stat_q.pkts);
    sq_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.op == OP_TICK) state_next = ST_TICK;
          else if (slots_used == '0) state_next = ST_NEW;
          else state_next = ST_LK_RD;
        end
      end
      ST_LK_RD: begin
        rd_en      = 1'b1;
        state_next = ST_LK_CMP;
      end
      ST_LK_CMP: begin
        if (key_q == cur.key) state_next = ST_UPD;
        else if (is_last) begin
          if (slots_used == CntW'(FLOW_SLOTS)) state_next = ST_IDLE;
          else state_next = ST_NEW;
        end else state_next = ST_LK_RD;
      end
      ST_NEW: begin
        key_we           = 1'b1;
        stat_we          = 1'b1;
        waddr            = slots_used[SlotW-1:0];
        stat_wdata.pkts  = 32'd1;
        stat_wdata.bytes = 48'(cur.len);
        stat_wdata.sqsum = 64'(cur.sq);
        stat_wdata.start = cur.now;
        stat_wdata.cls   = cur.cls;
        state_next       = ST_IDLE;
      end
      ST_UPD: begin
        stat_we          = 1'b1;
        stat_wdata.pkts  = (stat_q.pkts == Max32) ? Max32 : stat_q.pkts + 32'd1;
        stat_wdata.bytes = bytes_sum[48] ? Max48 : bytes_sum[47:0];
        stat_wdata.sqsum = sq_sum[64] ? Max64 : sq_sum[63:0];
        state_next       = ST_IDLE;
      end
      ST_TICK: begin
        if ({1'b0, cur.now} < tick_end) state_next = ST_IDLE;
        else if (slots_used == '0) state_next = ST_CLOSE;
        else state_next = ST_FL_RD;
      end
      ST_FL_RD: begin
        rd_en      = 1'b1;
        state_next = ST_FL_MUL;
      end
      ST_FL_MUL: begin
        if (mstep == 3'd6) begin
          div_start  = 1'b1;
          state_next = ST_FL_MEAN;
        end
      end
      ST_FL_MEAN: begin
        if (div_done) begin
          if (std_needed) begin
            div_start  = 1'b1;
            div_num    = {diff, 16'd0};
            div_den    = den;
            state_next = ST_FL_STD;
          end else state_next = ST_EMIT;
        end
      end
      ST_FL_STD: begin
        if (div_done) begin
          if (div_ovf || (div_q > Max48)) state_next = ST_EMIT;
          else begin
            sq_start   = 1'b1;
            state_next = ST_FL_ROOT;
          end
        end
      end
      ST_FL_ROOT: begin
        if (sq_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = is_last ? ST_CLOSE : ST_FL_RD;
      end
      ST_CLOSE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) cur <= item;
    if (state == ST_FL_RD) begin
      acc_a <= '0;
      acc_b <= '0;
      mstep <= 3'd0;
    end
    if (state == ST_FL_MUL) begin
      prod  <= mul_p;
      mstep <= mstep + 3'd1;
      unique case (mstep)
        3'd1:    acc_a <= acc_a + 96'(prod);
        3'd2:    acc_a <= acc_a + (96'(prod) << 32);
        3'd3:    acc_b <= acc_b + 96'(prod);
        3'd4:    acc_b <= acc_b + (96'(prod) << 33);
        3'd5:    acc_b <= acc_b + (96'(prod) << 64);
        3'd6:    den   <= prod;
        default: ;
      endcase
    end
    if (state == ST_FL_MEAN && div_done) begin
      mean <= (div_ovf || (div_q > 48'(Max24))) ? Max24 : div_q[23:0];
      stdv <= '0;
    end
    if (state == ST_FL_STD && div_done) stdv <= Max24;
    if (state == ST_FL_ROOT && sq_done) stdv <= sq_root;
    if (state == ST_TICK) win_end <= tick_end;
    if (state == ST_EMIT && out_free) begin
      rec.pkt_total       <= stat_q.pkts;
      rec.byte_total      <= stat_q.bytes;
      rec.mean_size       <= mean;
      rec.std_size        <= stdv;
      rec.flow_age_ms     <= (cur.now >= stat_q.start) ? cur.now - stat_q.start : '0;
      rec.tcp_flag        <= (stat_q.cls == CLS_TCP);
      rec.udp_flag        <= (stat_q.cls == CLS_UDP);
      rec.icmp_flag       <= (stat_q.cls == CLS_ICMP);
      rec.dropped_packets <= drop;
      rec.last_record     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 32'd1000;
      window_start  <= '0;
      slots_used    <= '0;
      drop          <= '0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW_LENGTH: window_length <= cfg_data[31:0];
          CFG_FIRST_START:   window_start  <= cfg_data;
        endcase
      end
      if (state == ST_IDLE) idx <= '0;
      if (state == ST_LK_CMP) begin
        if (key_q != cur.key && is_last && slots_used == CntW'(FLOW_SLOTS)) begin
          if (drop != Max16) drop <= drop + 16'd1;
        end else if (key_q != cur.key && !is_last) idx <= idx + SlotW'(1);
      end
      if (state == ST_NEW) slots_used <= slots_used + CntW'(1);
      if (state == ST_TICK) idx <= '0;
      if (state == ST_EMIT && out_free && !is_last) idx <= idx + SlotW'(1);
      if (state == ST_CLOSE) begin
        slots_used   <= '0;
        drop         <= '0;
        window_start <= win_end[48] ? Max48 : win_end[47:0];
      end
      if (state == ST_EMIT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CntW'(FLOW_SLOTS))
    else $error("slot count beyond table size");

  a_new_has_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_NEW |-> slots_used < CntW'(FLOW_SLOTS))
    else $error("new flow on a full table");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLOSE |=> slots_used == '0 && drop == '0)
    else $error("table not emptied after flush");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_free |=> out_valid)
    else $error("record not presented");

endmodule

### rtl/core/windowed_flow_statistics.sv
// Windowed flow statistics: top level, front end, queue and table engine.
// Depends on wfs_pkg, wfs_front and wfs_back.
//
// Input channel (in_valid/in_ready) takes packet and tick items; output
// channel (out_valid/out_ready) gives one flow record per used slot when a
// tick closes the window, in slot order, last_record marking the final one.
// cfg_write_en/cfg_index/cfg_data write window length (0) and first window
// start (1); writing the start also loads the current window start.
// A two-entry queue sits between the front end and the table engine, so
// items are taken while the engine works or a record waits.
// A packet is taken, then written at once when the table has no flows;
// else slots are compared in turn (one key RAM read each) until the key
// matches, and it is written as an update or new flow, or dropped if the
// table is full. A tick that ends the window reads each flow, divides
// for the mean (112 steps) and, if needed, the variance (112) and root
// (24), then closes; a record waits in the output register while the
// receiver stalls, and the engine stops at the next one until it is taken.
// Reset empties the table and queue, zeroes the drop count, sets window
// length to 1000 ms and window start to 0.
module windowed_flow_statistics #(
  parameter int FLOW_SLOTS = wfs_pkg::FlowSlotsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [63:0] flow_key,
  input  logic [15:0] packet_bytes,
  input  logic [7:0]  protocol_number,
  input  logic [47:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pkt_total,
  output logic [47:0] byte_total,
  output logic [23:0] mean_size,
  output logic [23:0] std_size,
  output logic [47:0] flow_age_ms,
  output logic        tcp_flag,
  output logic        udp_flag,
  output logic        icmp_flag,
  output logic [15:0] dropped_packets,
  output logic        last_record
);
  import wfs_pkg::*;

  logic  item_valid;
  logic  item_ready;
  item_t item;
  rec_t  rec;

  wfs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .flow_key(flow_key), .packet_bytes(packet_bytes),
    .protocol_number(protocol_number), .now_ms(now_ms),
    .item_valid(item_valid), .item_ready(item_ready), .item(item)
  );

  wfs_back #(.FLOW_SLOTS(FLOW_SLOTS)) u_back (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item_valid(item_valid), .item_ready(item_ready),
    .item(item), .out_valid(out_valid), .out_ready(out_ready), .rec(rec)
  );

  assign pkt_total       = rec.pkt_total;
  assign byte_total      = rec.byte_total;
  assign mean_size       = rec.mean_size;
  assign std_size        = rec.std_size;
  assign flow_age_ms     = rec.flow_age_ms;
  assign tcp_flag        = rec.tcp_flag;
  assign udp_flag        = rec.udp_flag;
  assign icmp_flag       = rec.icmp_flag;
  assign dropped_packets = rec.dropped_packets;
  assign last_record     = rec.last_record;

endmodule
